// ===== rtl/swoa_pkg.sv =====
`default_nettype none

package swoa_pkg;

    // sonar front end
    localparam int NUM_SONARS   = 16;
    localparam int READING_BITS = 10;
    localparam int IDX_W        = 4;

    // sums and nearness modifier
    localparam int SUM_W     = 21;
    localparam int MODV_W    = 10;
    localparam int WEIGHT_W  = 10;
    localparam int PROD_W    = MODV_W + WEIGHT_W;
    localparam int SCALED_W  = READING_BITS + 14;
    localparam int MOD_OFFSET = 9216;
    localparam int MOD_SCALE  = 10 * 1024;

    // configuration
    localparam int CFG_DATA_W = 11;
    localparam int CFG_ADDR_W = 2;
    localparam int SPEED_IN_W = 11;
    localparam int PERIOD_W   = 7;
    localparam int SPEED_W    = 12;
    localparam int MODE_W     = 2;
    localparam int LED_W      = 2;

    localparam logic [CFG_ADDR_W-1:0] CFG_THRESHOLD = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_CRUISE    = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_TURN      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD    = 2'd3;

    localparam logic [CFG_DATA_W-1:0] THRESHOLD_RST = 11'd100;
    localparam logic [SPEED_IN_W-1:0] CRUISE_RST    = 11'd1341;
    localparam logic [SPEED_IN_W-1:0] TURN_RST      = 11'd939;
    localparam logic [PERIOD_W-1:0]   PERIOD_RST    = 7'd70;

    // heading modes
    localparam logic [MODE_W-1:0] MODE_FWD   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_LEFT  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_RIGHT = 2'd2;

    localparam logic [LED_W-1:0] LED_LAST = 2'd2;

    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 32;

    typedef struct packed {
        logic lhit;
        logic rhit;
    } t_hits;

    typedef struct packed {
        logic [LED_W-1:0]          active_led;
        logic [MODE_W-1:0]         heading_mode;
        logic signed [SPEED_W-1:0] right_speed;
        logic signed [SPEED_W-1:0] left_speed;
    } t_result;

    function automatic logic [WEIGHT_W-1:0] weight_left(input logic [IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            4'd0:    w = 10'd150;
            4'd1:    w = 10'd200;
            4'd2:    w = 10'd300;
            4'd3:    w = 10'd600;
            default: w = '0;
        endcase
        return w;
    endfunction

    function automatic logic [WEIGHT_W-1:0] weight_right(input logic [IDX_W-1:0] idx);
        logic [WEIGHT_W-1:0] w;
        case (idx)
            4'd4:    w = 10'd600;
            4'd5:    w = 10'd300;
            4'd6:    w = 10'd200;
            4'd7:    w = 10'd150;
            default: w = '0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sonar_weighted_obstacle_avoid_top.sv =====
// sonar weighted obstacle avoidance controller
//
// input stream: one sonar sample per request. tdata carries the raw reading,
// tuser the sonar index, tlast marks the final sample of a control scan.
// output stream: one result per scan, carrying signed q4.8 wheel speeds,
// the new heading mode and the lit led index.
// config: write enable, register index and data; the user must see that they are
// written only while idle, as the block itself does not enforce it.
// a sample is registered on accept and folded into the left and right sums
// as it leaves the input register; the block takes one sample every cycle
// unless a final sample waits behind an unaccepted result. a result is put
// in the output register as its tlast sample leaves the input register; the
// rate is set by the combinational weight, add and compare path between them.
// when the receiver stalls the result holds in the output register; the
// input side keeps taking non-final samples, and stops only when a final
// sample must wait behind an unaccepted result.
// reset clears the sums, the mode (forward), the scan count and the led,
// and loads the register defaults.
`default_nettype none

module sonar_weighted_obstacle_avoid_top
    import swoa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_s_tvalid,
    output logic                       o_s_tready,
    input  wire logic [IN_DATA_W-1:0]  i_s_tdata,   // [9:0] sensor_reading
    input  wire logic [IDX_W-1:0]      i_s_tuser,   // [3:0] sensor_index
    input  wire logic                  i_s_tlast,   // scan_last
    output logic                       o_m_tvalid,
    input  wire logic                  i_m_tready,
    // [11:0] left_speed, [23:12] right_speed, [25:24] heading_mode, [27:26] active_led
    output logic [OUT_DATA_W-1:0]      o_m_tdata,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [CFG_DATA_W-1:0]   r_threshold;
    logic [SPEED_IN_W-1:0]   r_cruise;
    logic [SPEED_IN_W-1:0]   r_turn;
    logic [PERIOD_W-1:0]     r_period;

    logic                    r_in_valid;
    logic [IDX_W-1:0]        r_in_idx;
    logic [READING_BITS-1:0] r_in_reading;
    logic                    r_in_last;

    logic                    r_out_valid;
    t_result                 r_out;

    logic                    w_accept;
    logic                    w_adv;
    logic                    w_scan_end;
    t_hits                   w_hits;
    t_result                 w_result;

    assign w_adv      = r_in_valid && (!r_in_last || !r_out_valid || i_m_tready);
    assign w_scan_end = w_adv && r_in_last;
    assign o_s_tready = !r_in_valid || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= THRESHOLD_RST;
            r_cruise    <= CRUISE_RST;
            r_turn      <= TURN_RST;
            r_period    <= PERIOD_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_addr)
                CFG_THRESHOLD: r_threshold <= i_cfg_data;
                CFG_CRUISE:    r_cruise    <= i_cfg_data;
                CFG_TURN:      r_turn      <= i_cfg_data;
                CFG_PERIOD:    r_period    <= i_cfg_data[PERIOD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_idx     <= i_s_tuser;
            r_in_reading <= i_s_tdata[READING_BITS-1:0];
            r_in_last    <= i_s_tlast;
        end
    end

    swoa_accum u_accum (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_fire      (w_adv),
        .i_idx       (r_in_idx),
        .i_reading   (r_in_reading),
        .i_last      (r_in_last),
        .i_threshold (r_threshold),
        .o_hits      (w_hits)
    );

    swoa_steer u_steer (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_scan_end (w_scan_end),
        .i_hits     (w_hits),
        .i_cruise   (r_cruise),
        .i_turn     (r_turn),
        .i_period   (r_period),
        .o_result   (w_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_scan_end) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_end) begin
            r_out <= w_result;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = OUT_DATA_W'(r_out);

`ifndef SYNTHESIS
    // a new result only follows a final sample leaving the input register
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_scan_end))
        else $error("result without a scan end");

    // forward mode drives both wheels at the same speed
    a_forward_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_out.heading_mode == MODE_FWD |->
        r_out.left_speed == r_out.right_speed)
        else $error("forward speeds differ");

    // turning spins in place
    a_turn_opposite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && r_out.heading_mode != MODE_FWD |->
        r_out.left_speed == -r_out.right_speed)
        else $error("turn speeds not opposite");

    // a final sample never overwrites a result that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_scan_end |-> !r_out_valid || i_m_tready)
        else $error("result overwritten");

    // a held sample stays in the input register
    a_hold_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !w_adv |=> r_in_valid && $stable(r_in_last))
        else $error("held sample lost");
`endif

endmodule

`default_nettype wire

// ===== rtl/swoa_accum.sv =====
`default_nettype none

module swoa_accum
    import swoa_pkg::*;
(
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_fire,
    input  wire logic [IDX_W-1:0]        i_idx,
    input  wire logic [READING_BITS-1:0] i_reading,
    input  wire logic                    i_last,
    input  wire logic [CFG_DATA_W-1:0]   i_threshold,
    output t_hits                        o_hits
);

    logic [SUM_W-1:0]    r_left_sum;
    logic [SUM_W-1:0]    r_right_sum;
    logic [SUM_W-1:0]    n_left_sum;
    logic [SUM_W-1:0]    n_right_sum;
    logic [SCALED_W-1:0] w_scaled;
    logic [SCALED_W-1:0] w_near;
    logic [MODV_W-1:0]   w_modv;
    logic [PROD_W-1:0]   w_lprod;
    logic [PROD_W-1:0]   w_rprod;
    logic [SUM_W:0]      w_lsum;
    logic [SUM_W:0]      w_rsum;
    logic [SUM_W-1:0]    w_thr;
    logic                w_in_range;

    // nearness modifier, floored at zero and capped to ten bits
    assign w_scaled = SCALED_W'((SCALED_W'(i_reading) * SCALED_W'(MOD_SCALE)) >> READING_BITS);
    assign w_near   = (w_scaled > SCALED_W'(MOD_OFFSET)) ?
                      (w_scaled - SCALED_W'(MOD_OFFSET)) : '0;
    assign w_modv   = (w_near > SCALED_W'({MODV_W{1'b1}})) ? {MODV_W{1'b1}} :
                      w_near[MODV_W-1:0];

    assign w_in_range = int'(i_idx) < NUM_SONARS;
    assign w_lprod = w_in_range ? PROD_W'(w_modv) * PROD_W'(weight_left(i_idx)) : '0;
    assign w_rprod = w_in_range ? PROD_W'(w_modv) * PROD_W'(weight_right(i_idx)) : '0;

    assign w_lsum = {1'b0, r_left_sum} + (SUM_W+1)'(w_lprod);
    assign w_rsum = {1'b0, r_right_sum} + (SUM_W+1)'(w_rprod);

    assign n_left_sum  = w_lsum[SUM_W] ? {SUM_W{1'b1}} : w_lsum[SUM_W-1:0];
    assign n_right_sum = w_rsum[SUM_W] ? {SUM_W{1'b1}} : w_rsum[SUM_W-1:0];

    assign w_thr       = {i_threshold, 10'b0};
    assign o_hits.lhit = n_left_sum > w_thr;
    assign o_hits.rhit = n_right_sum > w_thr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left_sum  <= '0;
            r_right_sum <= '0;
        end else if (i_fire) begin
            if (i_last) begin
                r_left_sum  <= '0;
                r_right_sum <= '0;
            end else begin
                r_left_sum  <= n_left_sum;
                r_right_sum <= n_right_sum;
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/swoa_steer.sv =====
`default_nettype none

module swoa_steer
    import swoa_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_scan_end,
    input  wire t_hits                 i_hits,
    input  wire logic [SPEED_IN_W-1:0] i_cruise,
    input  wire logic [SPEED_IN_W-1:0] i_turn,
    input  wire logic [PERIOD_W-1:0]   i_period,
    output t_result                    o_result
);

    logic [MODE_W-1:0]   r_mode;
    logic [MODE_W-1:0]   n_mode;
    logic [PERIOD_W-1:0] r_scan_cnt;
    logic [PERIOD_W-1:0] n_scan_cnt;
    logic [LED_W-1:0]    r_led;
    logic [LED_W-1:0]    n_led;
    logic [PERIOD_W-1:0] w_cnt_inc;
    logic signed [SPEED_W-1:0] w_cs;
    logic signed [SPEED_W-1:0] w_ts;
    logic signed [SPEED_W-1:0] n_left;
    logic signed [SPEED_W-1:0] n_right;

    assign w_cs = SPEED_W'(i_cruise);
    assign w_ts = SPEED_W'(i_turn);

    always_comb begin
        unique case (r_mode) inside
            MODE_LEFT, MODE_RIGHT: begin
                if (i_hits.lhit || i_hits.rhit) begin
                    n_mode  = r_mode;
                    n_left  = (r_mode == MODE_LEFT) ? w_ts : -w_ts;
                    n_right = (r_mode == MODE_LEFT) ? -w_ts : w_ts;
                end else begin
                    n_mode  = MODE_FWD;
                    n_left  = w_cs;
                    n_right = w_cs;
                end
            end
            default: begin
                // forward, and the unused code behaves the same
                if (i_hits.lhit) begin
                    n_mode  = MODE_LEFT;
                    n_left  = w_ts;
                    n_right = -w_ts;
                end else if (i_hits.rhit) begin
                    n_mode  = MODE_RIGHT;
                    n_left  = -w_ts;
                    n_right = w_ts;
                end else begin
                    n_mode  = MODE_FWD;
                    n_left  = w_cs;
                    n_right = w_cs;
                end
            end
        endcase
    end

    assign w_cnt_inc = r_scan_cnt + PERIOD_W'(1);

    always_comb begin
        if (w_cnt_inc >= i_period) begin
            n_scan_cnt = '0;
            n_led      = (r_led == LED_LAST) ? '0 : r_led + LED_W'(1);
        end else begin
            n_scan_cnt = w_cnt_inc;
            n_led      = r_led;
        end
    end

    assign o_result.left_speed   = n_left;
    assign o_result.right_speed  = n_right;
    assign o_result.heading_mode = n_mode;
    assign o_result.active_led   = n_led;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= MODE_FWD;
            r_scan_cnt <= '0;
            r_led      <= '0;
        end else if (i_scan_end) begin
            r_mode     <= n_mode;
            r_scan_cnt <= n_scan_cnt;
            r_led      <= n_led;
        end
    end

endmodule

`default_nettype wire

// ===== verif/sonar_weighted_obstacle_avoid_top_tb.sv =====
`default_nettype none

module sonar_weighted_obstacle_avoid_top_tb;
    import swoa_pkg::*;

    localparam int SETTLE_CYCLES  = 6;
    localparam int TAIL_CYCLES    = 10;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TOTAL_SAMPLES  = 920;
    localparam int unsigned SUM_CAP = (1 << SUM_W) - 1;

    typedef enum {ROW_SAMPLE, ROW_REG} t_row_kind;

    typedef struct {
        t_row_kind                kind;
        logic [IDX_W-1:0]         idx;
        logic [READING_BITS-1:0]  rd;
        logic                     lst;
        logic [CFG_ADDR_W-1:0]    sel;
        logic [CFG_DATA_W-1:0]    val;
        bit                       typed;
        t_result                  want;
    } t_stim_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_s_tvalid;
    logic                  o_s_tready;
    logic [IN_DATA_W-1:0]  i_s_tdata;   // [9:0] sensor_reading
    logic [IDX_W-1:0]      i_s_tuser;   // [3:0] sensor_index
    logic                  i_s_tlast;   // scan_last
    logic                  o_m_tvalid;
    logic                  i_m_tready;
    // [11:0] left_speed, [23:12] right_speed, [25:24] heading_mode, [27:26] active_led
    logic [OUT_DATA_W-1:0] o_m_tdata;
    logic                  i_cfg_wr_en;
    logic [CFG_ADDR_W-1:0] i_cfg_addr;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    sonar_weighted_obstacle_avoid_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_s_tlast   (i_s_tlast),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data)
    );

    // controller copy: registers and state
    logic [CFG_DATA_W-1:0] cfg_thr;
    logic [SPEED_IN_W-1:0] cfg_cruise;
    logic [SPEED_IN_W-1:0] cfg_turn;
    logic [PERIOD_W-1:0]   cfg_period;
    int unsigned           near_sum_l;
    int unsigned           near_sum_r;
    logic [MODE_W-1:0]     heading;
    logic [PERIOD_W-1:0]   scan_cnt;
    logic [LED_W-1:0]      led_sel;

    t_result   pending_steer[$];
    t_stim_row dir_rows[$];
    int        mismatch_count = 0;
    int        sample_count   = 0;
    int        quiet_cycles   = 0;
    bit        s_gaps_on      = 1'b1;
    bit        m_gaps_on      = 1'b1;
    t_result   seen_res;
    t_result   due_res;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    // folds one sample into the sums; returns 1 when it closes a scan
    function automatic bit predict_steer(input logic [IDX_W-1:0] idx,
                                         input logic [READING_BITS-1:0] rd,
                                         input logic lst, output t_result res);
        int unsigned nearness;
        int unsigned wl;
        int unsigned wr;
        int unsigned limit;
        bit lhit;
        bit rhit;
        logic signed [SPEED_W-1:0] cs;
        logic signed [SPEED_W-1:0] ts;
        res = '0;
        wl = 0;
        wr = 0;
        case (idx)
            4'd0: wl = 150;
            4'd1: wl = 200;
            4'd2: wl = 300;
            4'd3: wl = 600;
            4'd4: wr = 600;
            4'd5: wr = 300;
            4'd6: wr = 200;
            4'd7: wr = 150;
            default: ;
        endcase
        nearness = (int'(rd) * 10240) >> READING_BITS;
        nearness = (nearness > MOD_OFFSET) ? nearness - MOD_OFFSET : 0;
        if (nearness > 1023)
            nearness = 1023;
        near_sum_l = (near_sum_l + nearness * wl > SUM_CAP) ? SUM_CAP
                                                            : near_sum_l + nearness * wl;
        near_sum_r = (near_sum_r + nearness * wr > SUM_CAP) ? SUM_CAP
                                                            : near_sum_r + nearness * wr;
        if (!lst)
            return 1'b0;

        limit = int'(cfg_thr) * 1024;
        lhit  = near_sum_l > limit;
        rhit  = near_sum_r > limit;
        cs    = $signed({1'b0, cfg_cruise});
        ts    = $signed({1'b0, cfg_turn});

        if (heading == MODE_LEFT || heading == MODE_RIGHT) begin
            // keep spinning the same way while anything is close
            if (lhit || rhit) begin
                res.left_speed  = (heading == MODE_LEFT) ? ts : -ts;
                res.right_speed = -res.left_speed;
            end else begin
                res.left_speed  = cs;
                res.right_speed = cs;
                heading         = MODE_FWD;
            end
        end else if (lhit) begin
            res.left_speed  = ts;
            res.right_speed = -ts;
            heading         = MODE_LEFT;
        end else if (rhit) begin
            res.left_speed  = -ts;
            res.right_speed = ts;
            heading         = MODE_RIGHT;
        end else begin
            res.left_speed  = cs;
            res.right_speed = cs;
            heading         = MODE_FWD;
        end

        scan_cnt = scan_cnt + 1'b1;
        if (scan_cnt >= cfg_period) begin
            led_sel  = (led_sel == LED_LAST) ? '0 : led_sel + 1'b1;
            scan_cnt = '0;
        end
        res.heading_mode = heading;
        res.active_led   = led_sel;
        near_sum_l = 0;
        near_sum_r = 0;
        return 1'b1;
    endfunction

    task automatic push_sample(input logic [IDX_W-1:0] idx, input logic [READING_BITS-1:0] rd,
                               input logic lst, input bit typed, input t_result typed_res);
        int gap;
        t_result res;
        gap = s_gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {{(IN_DATA_W-READING_BITS){1'b0}}, rd};
        i_s_tuser  <= idx;
        i_s_tlast  <= lst;
        do @(posedge i_clk); while (!o_s_tready);
        if (predict_steer(idx, rd, lst, res))
            pending_steer.push_back(typed ? typed_res : res);
        sample_count++;
    endtask

    task automatic drain_results(input int extra);
        i_s_tvalid <= 1'b0;
        while (pending_steer.size() != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] sel, input logic [CFG_DATA_W-1:0] val);
        drain_results(SETTLE_CYCLES);
        i_cfg_wr_en <= 1'b1;
        i_cfg_addr  <= sel;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        case (sel)
            CFG_THRESHOLD: cfg_thr    = val;
            CFG_CRUISE:    cfg_cruise = val;
            CFG_TURN:      cfg_turn   = val;
            CFG_PERIOD:    cfg_period = val[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    function automatic t_stim_row smp(input int idx, input int rd, input bit lst);
        t_stim_row r;
        r.kind  = ROW_SAMPLE;
        r.idx   = IDX_W'(idx);
        r.rd    = READING_BITS'(rd);
        r.lst   = lst;
        r.sel   = '0;
        r.val   = '0;
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    function automatic t_stim_row smp_chk(input int idx, input int rd, input int ls, input int rs,
                                          input logic [MODE_W-1:0] m, input int led);
        t_stim_row r;
        r = smp(idx, rd, 1'b1);
        r.typed             = 1'b1;
        r.want.left_speed   = SPEED_W'(ls);
        r.want.right_speed  = SPEED_W'(rs);
        r.want.heading_mode = m;
        r.want.active_led   = LED_W'(led);
        return r;
    endfunction

    function automatic t_stim_row reg_row(input logic [CFG_ADDR_W-1:0] sel, input int val);
        t_stim_row r;
        r.kind  = ROW_REG;
        r.idx   = '0;
        r.rd    = '0;
        r.lst   = 1'b0;
        r.sel   = sel;
        r.val   = CFG_DATA_W'(val);
        r.typed = 1'b0;
        r.want  = '0;
        return r;
    endfunction

    // receiver: random stall before each result
    initial begin
        int stall;
        i_m_tready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            stall = m_gaps_on ? $urandom_range(0, 10) : 0;
            if (stall > 0) begin
                i_m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_m_tready <= 1'b1;
            do @(posedge i_clk); while (!o_m_tvalid);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            seen_res = t_result'(o_m_tdata[$bits(t_result)-1:0]);
            if (pending_steer.size() == 0) begin
                flag_mismatch($sformatf("result %h with nothing expected", o_m_tdata));
            end else begin
                due_res = pending_steer.pop_front();
                if (seen_res.left_speed !== due_res.left_speed)
                    flag_mismatch($sformatf("left_speed %0d, expected %0d",
                                            seen_res.left_speed, due_res.left_speed));
                if (seen_res.right_speed !== due_res.right_speed)
                    flag_mismatch($sformatf("right_speed %0d, expected %0d",
                                            seen_res.right_speed, due_res.right_speed));
                if (seen_res.heading_mode !== due_res.heading_mode)
                    flag_mismatch($sformatf("heading_mode %0d, expected %0d",
                                            seen_res.heading_mode, due_res.heading_mode));
                if (seen_res.active_led !== due_res.active_led)
                    flag_mismatch($sformatf("active_led %0d, expected %0d",
                                            seen_res.active_led, due_res.active_led));
            end
        end
    end

    // watchdog on handshake activity
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int len;
        int nscans;
        logic [IDX_W-1:0] idx;
        logic [READING_BITS-1:0] rd;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_s_tuser   <= '0;
        i_s_tlast   <= 1'b0;
        i_cfg_wr_en <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_data  <= '0;

        cfg_thr    = THRESHOLD_RST;
        cfg_cruise = CRUISE_RST;
        cfg_turn   = TURN_RST;
        cfg_period = PERIOD_RST;
        near_sum_l = 0;
        near_sum_r = 0;
        heading    = MODE_FWD;
        scan_cnt   = '0;
        led_sel    = '0;

        // register defaults: threshold 100, cruise 1341, turn 939
        dir_rows.push_back(smp_chk(0, 0, 1341, 1341, MODE_FWD, 0));
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp_chk(15, 1023, 939, -939, MODE_LEFT, 0));
        // right side close while spinning left keeps the spin
        dir_rows.push_back(smp_chk(4, 1023, 939, -939, MODE_LEFT, 0));
        // 921 is the last reading with zero nearness
        dir_rows.push_back(smp_chk(0, 921, 1341, 1341, MODE_FWD, 0));
        dir_rows.push_back(smp_chk(4, 922, 1341, 1341, MODE_FWD, 0));
        dir_rows.push_back(smp_chk(4, 1023, -939, 939, MODE_RIGHT, 0));
        dir_rows.push_back(smp_chk(7, 1023, -939, 939, MODE_RIGHT, 0));
        dir_rows.push_back(smp_chk(8, 1023, 1341, 1341, MODE_FWD, 0));
        // both sides close from forward: left wins
        dir_rows.push_back(smp(0, 1023, 1'b0));
        dir_rows.push_back(smp_chk(7, 1023, 939, -939, MODE_LEFT, 0));
        // left sum saturates
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp_chk(3, 1023, 939, -939, MODE_LEFT, 0));
        // sum equal to threshold does not count as close
        dir_rows.push_back(reg_row(CFG_THRESHOLD, 75));
        dir_rows.push_back(reg_row(CFG_CRUISE, 2047));
        dir_rows.push_back(reg_row(CFG_TURN, 0));
        dir_rows.push_back(reg_row(CFG_PERIOD, 1));
        dir_rows.push_back(smp(1, 960, 1'b1));
        dir_rows.push_back(smp(1, 961, 1'b1));
        // saturated sum just above the largest threshold, led moves every scan
        dir_rows.push_back(reg_row(CFG_THRESHOLD, 2047));
        dir_rows.push_back(reg_row(CFG_CRUISE, 0));
        dir_rows.push_back(reg_row(CFG_TURN, 2047));
        dir_rows.push_back(reg_row(CFG_PERIOD, 0));
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp(2, 1023, 1'b0));
        dir_rows.push_back(smp(3, 1023, 1'b0));
        dir_rows.push_back(smp(3, 1023, 1'b1));
        dir_rows.push_back(smp(0, 1023, 1'b1));
        dir_rows.push_back(smp(12, 0, 1'b1));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (dir_rows[k]) begin
            if (dir_rows[k].kind == ROW_REG)
                write_reg(dir_rows[k].sel, dir_rows[k].val);
            else
                push_sample(dir_rows[k].idx, dir_rows[k].rd, dir_rows[k].lst,
                            dir_rows[k].typed, dir_rows[k].want);
        end

        while (sample_count < TOTAL_SAMPLES) begin
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_THRESHOLD, CFG_DATA_W'(0));
                1:       write_reg(CFG_THRESHOLD, CFG_DATA_W'(2047));
                default: write_reg(CFG_THRESHOLD, CFG_DATA_W'($urandom_range(0, 700)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_CRUISE, CFG_DATA_W'(0));
                1:       write_reg(CFG_CRUISE, CFG_DATA_W'(2047));
                default: write_reg(CFG_CRUISE, CFG_DATA_W'($urandom_range(0, 2047)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_TURN, CFG_DATA_W'(0));
                1:       write_reg(CFG_TURN, CFG_DATA_W'(2047));
                default: write_reg(CFG_TURN, CFG_DATA_W'($urandom_range(0, 2047)));
            endcase
            case ($urandom_range(0, 5))
                0:       write_reg(CFG_PERIOD, CFG_DATA_W'(1));
                1:       write_reg(CFG_PERIOD, CFG_DATA_W'(127));
                default: write_reg(CFG_PERIOD, CFG_DATA_W'($urandom_range(1, 6)));
            endcase
            s_gaps_on = ($urandom_range(0, 3) != 0);
            m_gaps_on = ($urandom_range(0, 3) != 0);
            nscans = $urandom_range(4, 12);
            repeat (nscans) begin
                len = $urandom_range(1, 10);
                for (int j = 0; j < len; j++) begin
                    // mostly weighted sonars and near readings, some noise
                    idx = ($urandom_range(0, 4) == 0) ? IDX_W'($urandom_range(0, 15))
                                                      : IDX_W'($urandom_range(0, 7));
                    rd  = ($urandom_range(0, 2) == 0) ? READING_BITS'($urandom_range(0, 1023))
                                                      : READING_BITS'($urandom_range(880, 1023));
                    push_sample(idx, rd, j == len - 1, 1'b0, '0);
                end
            end
        end

        drain_results(TAIL_CYCLES);
        if (mismatch_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sonar_weighted_obstacle_avoid_top.f =====
rtl/swoa_pkg.sv
rtl/swoa_accum.sv
rtl/swoa_steer.sv
rtl/sonar_weighted_obstacle_avoid_top.sv
verif/sonar_weighted_obstacle_avoid_top_tb.sv
